// ===== rtl/core/i2cms_pkg.sv =====
// ============================================================================
// I2C master bit sequencer package
// Shared types, command and status codes, phase encoding and sizing constants.
// ============================================================================
package i2cms_pkg;

    localparam int DEF_BUF_DEPTH = 64;
    localparam int SLOT_W        = 6;
    localparam int COUNT_W       = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ADDR_NACK = 2'd1,
        ST_DATA_NACK = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_ST2  = 5'd3,
        PH_WB0  = 5'd4,
        PH_WB1  = 5'd5,
        PH_WB2  = 5'd6,
        PH_WA0  = 5'd7,
        PH_WA1  = 5'd8,
        PH_WA2  = 5'd9,
        PH_RB1  = 5'd10,
        PH_RB2  = 5'd11,
        PH_RK0  = 5'd12,
        PH_RK1  = 5'd13,
        PH_RK2  = 5'd14,
        PH_RK3  = 5'd15,
        PH_SP0  = 5'd16,
        PH_SP1  = 5'd17,
        PH_SP2  = 5'd18
    } phase_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [7:0]         data;
    } buf_wr_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done;
        logic [1:0] status;
    } seq_res_t;

endpackage

// ===== rtl/core/i2cms_buf.sv =====
// ============================================================================
// Transmit byte buffer
// Single-port-write, single-read synchronous memory with a registered read,
// plus forwarding of the write made in the previous cycle.
// ============================================================================
module i2cms_buf #(
    parameter int BUF_DEPTH = i2cms_pkg::DEF_BUF_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2cms_pkg::buf_wr_t          wr,
    input  logic [i2cms_pkg::COUNT_W-1:0] rd_index,
    output logic [7:0]                  rd_byte
);
    import i2cms_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0]         mem [BUF_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               fwd_valid_reg;
    logic               fwd_valid_next;
    logic [AW-1:0]      fwd_addr_reg;
    logic [7:0]         fwd_data_reg;
    logic [COUNT_W-1:0] slot_wide;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    assign slot_wide      = COUNT_W'(wr.slot);
    assign wr_addr        = slot_wide[AW-1:0];
    assign rd_addr        = rd_index[AW-1:0];
    assign fwd_valid_next = wr.en && (slot_wide < COUNT_W'(BUF_DEPTH));

    always_ff @(posedge clk)
    begin
        if (fwd_valid_next)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_addr_reg  <= rd_addr;
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // A write in the previous cycle is not yet visible in the registered read.
    assign rd_byte = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                       : rd_data_reg;

endmodule

// ===== rtl/core/i2cms_seq.sv =====
// ============================================================================
// I2C phase sequencer
// Phase state machine that advances one bus phase per tick request and
// fetches transmit bytes from the buffer memory.
// ============================================================================
module i2cms_seq #(
    parameter int BUF_DEPTH = i2cms_pkg::DEF_BUF_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  i2cms_pkg::cmd_t               cmd,
    input  logic [6:0]                    address,
    input  logic [i2cms_pkg::COUNT_W-1:0] byte_count,
    input  logic                          sda_in,
    input  logic [7:0]                    rd_byte,
    output logic [i2cms_pkg::COUNT_W-1:0] rd_index,
    output i2cms_pkg::seq_res_t           res
);
    import i2cms_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(BUF_DEPTH);

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_cnt_reg, bit_cnt_next, bit_cnt_inc;
    logic [7:0]         shift_reg, shift_next;
    logic [COUNT_W-1:0] byte_idx_reg, byte_idx_next, byte_idx_inc;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               rmode_reg, rmode_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         rx_hold_reg, rx_hold_next;
    logic               in_addr_reg, in_addr_next;
    logic               rx_valid;
    logic               done;
    logic [COUNT_W:0]   ack_cmp;
    logic [7:0]         rx_shift;

    assign bit_cnt_inc  = bit_cnt_reg + 4'd1;
    assign byte_idx_inc = byte_idx_reg + COUNT_W'(1);
    assign ack_cmp      = {1'b0, byte_idx_reg} + (COUNT_W+1)'(1);
    assign rx_shift     = {shift_reg[6:0], sda_in};

    always_comb
    begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        byte_idx_next = byte_idx_reg;
        total_next    = total_reg;
        rmode_next    = rmode_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        status_next   = status_reg;
        rx_hold_next  = rx_hold_reg;
        in_addr_next  = in_addr_reg;
        rx_valid      = 1'b0;
        done          = 1'b0;
        if (cmd == CMD_WRITE || cmd == CMD_READ)
        begin
            if (phase_reg == PH_IDLE)
            begin
                rmode_next = (cmd == CMD_READ);
                if (cmd == CMD_WRITE && byte_count > DEPTH_C)
                begin
                    total_next = DEPTH_C;
                end
                else
                begin
                    total_next = byte_count;
                end
                shift_next    = {address, (cmd == CMD_READ)};
                bit_cnt_next  = 4'd0;
                byte_idx_next = '0;
                status_next   = ST_OK;
                in_addr_next  = 1'b1;
                phase_next    = PH_ST0;
            end
        end
        else if (cmd == CMD_TICK)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_ST0:
                begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST1;
                end
                PH_ST1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST2;
                end
                PH_ST2:
                begin
                    scl_next     = 1'b0;
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_WB0;
                end
                PH_WB0:
                begin
                    sda_next   = shift_reg[7];
                    phase_next = PH_WB1;
                end
                PH_WB1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WB2;
                end
                PH_WB2:
                begin
                    scl_next     = 1'b0;
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_inc;
                    phase_next   = (bit_cnt_inc >= 4'd8) ? PH_WA0 : PH_WB0;
                end
                PH_WA0:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_WA1;
                end
                PH_WA1:
                begin
                    scl_next = 1'b1;
                    if (sda_in)
                    begin
                        status_next = in_addr_reg ? ST_ADDR_NACK : ST_DATA_NACK;
                    end
                    phase_next = PH_WA2;
                end
                PH_WA2:
                begin
                    scl_next = 1'b0;
                    if (status_reg != ST_OK)
                    begin
                        phase_next = PH_SP0;
                    end
                    else if (in_addr_reg && rmode_reg)
                    begin
                        in_addr_next = 1'b0;
                        if (total_reg == '0)
                        begin
                            phase_next = PH_SP0;
                        end
                        else
                        begin
                            bit_cnt_next = 4'd0;
                            shift_next   = 8'd0;
                            phase_next   = PH_RB1;
                        end
                    end
                    else
                    begin
                        in_addr_next = 1'b0;
                        if (byte_idx_reg < total_reg && byte_idx_reg < DEPTH_C)
                        begin
                            shift_next    = rd_byte;
                            byte_idx_next = byte_idx_inc;
                            bit_cnt_next  = 4'd0;
                            phase_next    = PH_WB0;
                        end
                        else
                        begin
                            phase_next = PH_SP0;
                        end
                    end
                end
                PH_RB1:
                begin
                    sda_next     = 1'b1;
                    scl_next     = 1'b1;
                    shift_next   = rx_shift;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc >= 4'd8)
                    begin
                        rx_valid     = 1'b1;
                        rx_hold_next = rx_shift;
                    end
                    phase_next = PH_RB2;
                end
                PH_RB2:
                begin
                    scl_next   = 1'b0;
                    phase_next = (bit_cnt_reg >= 4'd8) ? PH_RK0 : PH_RB1;
                end
                PH_RK0:
                begin
                    sda_next   = (ack_cmp < {1'b0, total_reg}) ? 1'b0 : 1'b1;
                    phase_next = PH_RK1;
                end
                PH_RK1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RK2;
                end
                PH_RK2:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_RK3;
                end
                PH_RK3:
                begin
                    sda_next      = 1'b1;
                    byte_idx_next = byte_idx_inc;
                    if (byte_idx_inc < total_reg)
                    begin
                        bit_cnt_next = 4'd0;
                        shift_next   = 8'd0;
                        phase_next   = PH_RB1;
                    end
                    else
                    begin
                        phase_next = PH_SP0;
                    end
                end
                PH_SP0:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_SP1;
                end
                PH_SP1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_SP2;
                end
                PH_SP2:
                begin
                    sda_next   = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            byte_idx_reg <= '0;
            total_reg    <= '0;
            rmode_reg    <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            status_reg   <= ST_OK;
            rx_hold_reg  <= 8'd0;
            in_addr_reg  <= 1'b0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            byte_idx_reg <= byte_idx_next;
            total_reg    <= total_next;
            rmode_reg    <= rmode_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            status_reg   <= status_next;
            rx_hold_reg  <= rx_hold_next;
            in_addr_reg  <= in_addr_next;
        end
    end

    // The buffer is read every cycle at the index that will be current next cycle.
    assign rd_index = en ? byte_idx_next : byte_idx_reg;

    assign res.scl      = scl_next;
    assign res.sda      = sda_next;
    assign res.busy     = (phase_next != PH_IDLE);
    assign res.rx_valid = rx_valid;
    assign res.rx_byte  = rx_hold_next;
    assign res.done     = done;
    assign res.status   = status_next;

endmodule

// ===== rtl/core/i2c_master_bit_sequencer_top.sv =====
// ============================================================================
// I2C master bit sequencer
// Output: the result of each accepted request is registered in the output register.
// Throughput: one request per cycle while m_tready does not stall the output; the buffer
// memory read and its forwarding path keep up with back-to-back ticks.
// Reset: asynchronous, active low; lines released high, sequencer idle, status 0.
// ============================================================================
module i2c_master_bit_sequencer_top #(
    parameter int BUF_DEPTH = i2cms_pkg::DEF_BUF_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[6:0], byte_count[22:7], buf_index[28:23], data_byte[36:29],
    // sda_in[37], zero fill [39:38]
    input  logic [39:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_out[0], sda_out[1], busy_res[2], rx_valid[3], rx_byte[11:4],
    // done_res[12], status[14:13], zero fill [15]
    output logic [15:0] m_tdata
);
    import i2cms_pkg::*;

    logic                 accept;
    cmd_t                 cmd;
    buf_wr_t              wr;
    logic [COUNT_W-1:0]   rd_index;
    logic [7:0]           rd_byte;
    seq_res_t             res;
    logic                 m_valid_reg;
    logic [15:0]          m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    assign wr.en   = accept && (cmd == CMD_LOAD);
    assign wr.slot = s_tdata[28:23];
    assign wr.data = s_tdata[36:29];

    i2cms_buf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_index (rd_index),
        .rd_byte  (rd_byte)
    );

    i2cms_seq #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept),
        .cmd        (cmd),
        .address    (s_tdata[6:0]),
        .byte_count (s_tdata[22:7]),
        .sda_in     (s_tdata[37]),
        .rd_byte    (rd_byte),
        .rd_index   (rd_index),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {1'b0, res.status, res.done, res.rx_byte, res.rx_valid,
                           res.busy, res.sda, res.scl};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
